// ----- rtl/core/ist_pkg.sv -----
// Shared types and codes for the indexed sequence table.
`default_nettype none

package ist_pkg;

    localparam logic [2:0] REQ_INSERT = 3'd0;
    localparam logic [2:0] REQ_SORTED = 3'd1;
    localparam logic [2:0] REQ_ERASE  = 3'd2;
    localparam logic [2:0] REQ_REMOVE = 3'd3;
    localparam logic [2:0] REQ_GET    = 3'd4;
    localparam logic [2:0] REQ_SET    = 3'd5;
    localparam logic [2:0] REQ_FIND   = 3'd6;

    localparam int FIELD_W = 9;
    localparam int DATA_W  = 32;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DECIDE,
        ST_SCAN,
        ST_PLACE,
        ST_FIN
    } ist_state_t;

    typedef enum logic [2:0] {
        SC_SHIFT_UP,
        SC_SHIFT_DOWN,
        SC_SEARCH,
        SC_REMOVE,
        SC_GET,
        SC_FIND
    } ist_scan_t;

    typedef struct packed {
        logic req_valid;
        logic res_ready;
    } ist_ctl_in_t;

    typedef struct packed {
        logic req_ready;
        logic res_valid;
    } ist_ctl_out_t;

endpackage

`default_nettype wire

// ----- rtl/core/ist_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module ist_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// ----- rtl/core/ist_seq.sv -----
// Request sequencer: walks the store one entry per cycle for shifts, searches and removals.
`default_nettype none

module ist_seq import ist_pkg::*; #(
    parameter int DEPTH       = 256,
    parameter int VALUE_WIDTH = 32
) (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    input  wire ist_ctl_in_t                      ctl_i,
    output ist_ctl_out_t                          ctl_o,
    input  wire logic [2:0]                       req_type,
    input  wire logic [FIELD_W-1:0]               req_position,
    input  wire logic [DATA_W-1:0]                req_value,
    input  wire logic [$clog2(DEPTH+1)-1:0]       eff_capacity,
    output logic                                  res_status,
    output logic      [FIELD_W-1:0]               res_index,
    output logic      [DATA_W-1:0]                res_value,
    output logic      [FIELD_W-1:0]               res_occupancy,
    output logic                                  ram_we,
    output logic      [$clog2(DEPTH)-1:0]         ram_waddr,
    output logic      [VALUE_WIDTH-1:0]           ram_wdata,
    output logic      [$clog2(DEPTH)-1:0]         ram_raddr,
    input  wire logic [VALUE_WIDTH-1:0]           ram_rdata
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int WW = (CW > FIELD_W) ? CW : FIELD_W;
    localparam int XW = (VALUE_WIDTH > DATA_W) ? VALUE_WIDTH : DATA_W;

    ist_state_t             state_reg, state_next;
    ist_scan_t              op_reg, op_next;
    logic [2:0]             req_reg, req_next;
    logic [WW-1:0]          pos_reg, pos_next;
    logic [VALUE_WIDTH-1:0] val_reg, val_next;
    logic [CW-1:0]          count_reg, count_next;
    logic [CW-1:0]          rd_idx_reg, rd_idx_next;
    logic [CW-1:0]          rem_reg, rem_next;
    logic                   pipe_vld_reg, pipe_vld_next;
    logic [CW-1:0]          pipe_idx_reg, pipe_idx_next;
    logic [CW-1:0]          place_reg, place_next;
    logic [CW-1:0]          wr_idx_reg, wr_idx_next;
    logic [CW-1:0]          hit_reg, hit_next;
    logic                   status_reg, status_next;
    logic [CW-1:0]          rindex_reg, rindex_next;
    logic [VALUE_WIDTH-1:0] rvalue_reg, rvalue_next;

    logic [XW-1:0]          in_ext;
    logic [XW-1:0]          rv_ext;
    logic [WW-1:0]          idx_ext;
    logic [WW-1:0]          occ_ext;
    logic [WW-1:0]          cnt_w;
    logic [WW-1:0]          cap_w;
    logic [CW-1:0]          pos_c;

    assign in_ext  = XW'(req_value);
    assign rv_ext  = XW'(rvalue_reg);
    assign idx_ext = WW'(rindex_reg);
    assign occ_ext = WW'(count_reg);
    assign cnt_w   = WW'(count_reg);
    assign cap_w   = WW'(eff_capacity);
    assign pos_c   = pos_reg[CW-1:0];

    assign res_status    = status_reg;
    assign res_index     = idx_ext[FIELD_W-1:0];
    assign res_value     = rv_ext[DATA_W-1:0];
    assign res_occupancy = occ_ext[FIELD_W-1:0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            count_reg    <= '0;
            pipe_vld_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            pipe_vld_reg <= pipe_vld_next;
        end
        op_reg       <= op_next;
        req_reg      <= req_next;
        pos_reg      <= pos_next;
        val_reg      <= val_next;
        rd_idx_reg   <= rd_idx_next;
        rem_reg      <= rem_next;
        pipe_idx_reg <= pipe_idx_next;
        place_reg    <= place_next;
        wr_idx_reg   <= wr_idx_next;
        hit_reg      <= hit_next;
        status_reg   <= status_next;
        rindex_reg   <= rindex_next;
        rvalue_reg   <= rvalue_next;
    end

    always_comb begin
        state_next    = state_reg;
        op_next       = op_reg;
        req_next      = req_reg;
        pos_next      = pos_reg;
        val_next      = val_reg;
        count_next    = count_reg;
        rd_idx_next   = rd_idx_reg;
        rem_next      = rem_reg;
        pipe_vld_next = 1'b0;
        pipe_idx_next = pipe_idx_reg;
        place_next    = place_reg;
        wr_idx_next   = wr_idx_reg;
        hit_next      = hit_reg;
        status_next   = status_reg;
        rindex_next   = rindex_reg;
        rvalue_next   = rvalue_reg;
        ram_we        = 1'b0;
        ram_waddr     = '0;
        ram_wdata     = '0;
        ram_raddr     = rd_idx_reg[AW-1:0];
        ctl_o         = '0;

        case (state_reg)
            ST_IDLE: begin
                ctl_o.req_ready = 1'b1;
                if (ctl_i.req_valid) begin
                    req_next   = req_type;
                    pos_next   = WW'(req_position);
                    val_next   = in_ext[VALUE_WIDTH-1:0];
                    state_next = ST_DECIDE;
                end
            end
            ST_DECIDE: begin
                status_next = 1'b1;
                rindex_next = '0;
                rvalue_next = '0;
                state_next  = ST_FIN;
                case (req_reg)
                    REQ_INSERT: begin
                        if (cnt_w < cap_w && pos_reg <= cnt_w) begin
                            status_next = 1'b0;
                            place_next  = pos_c;
                            if (pos_reg < cnt_w) begin
                                op_next     = SC_SHIFT_UP;
                                rd_idx_next = count_reg - 1'b1;
                                rem_next    = count_reg - pos_c;
                                state_next  = ST_SCAN;
                            end else begin
                                state_next = ST_PLACE;
                            end
                        end
                    end
                    REQ_SORTED: begin
                        if (cnt_w < cap_w) begin
                            status_next = 1'b0;
                            op_next     = SC_SEARCH;
                            rd_idx_next = '0;
                            rem_next    = count_reg;
                            state_next  = ST_SCAN;
                        end
                    end
                    REQ_ERASE: begin
                        if (pos_reg < cnt_w) begin
                            status_next = 1'b0;
                            count_next  = count_reg - 1'b1;
                            op_next     = SC_SHIFT_DOWN;
                            rd_idx_next = pos_c + 1'b1;
                            rem_next    = count_reg - 1'b1 - pos_c;
                            state_next  = ST_SCAN;
                        end
                    end
                    REQ_REMOVE: begin
                        status_next = 1'b0;
                        op_next     = SC_REMOVE;
                        rd_idx_next = '0;
                        rem_next    = count_reg;
                        wr_idx_next = '0;
                        hit_next    = '0;
                        state_next  = ST_SCAN;
                    end
                    REQ_GET: begin
                        if (pos_reg < cnt_w) begin
                            op_next     = SC_GET;
                            rd_idx_next = pos_c;
                            rem_next    = CW'(1);
                            state_next  = ST_SCAN;
                        end
                    end
                    REQ_SET: begin
                        if (pos_reg < cnt_w) begin
                            status_next = 1'b0;
                            ram_we      = 1'b1;
                            ram_waddr   = pos_c[AW-1:0];
                            ram_wdata   = val_reg;
                        end
                    end
                    REQ_FIND: begin
                        op_next     = SC_FIND;
                        rd_idx_next = '0;
                        rem_next    = count_reg;
                        state_next  = ST_SCAN;
                    end
                    default: begin
                    end
                endcase
            end
            ST_SCAN: begin
                if (rem_reg != '0) begin
                    pipe_vld_next = 1'b1;
                    pipe_idx_next = rd_idx_reg;
                    rd_idx_next   = (op_reg == SC_SHIFT_UP) ? rd_idx_reg - 1'b1
                                                            : rd_idx_reg + 1'b1;
                    rem_next      = rem_reg - 1'b1;
                end
                if (pipe_vld_reg) begin
                    case (op_reg)
                        SC_SHIFT_UP: begin
                            ram_we    = 1'b1;
                            ram_waddr = AW'(pipe_idx_reg + 1'b1);
                            ram_wdata = ram_rdata;
                        end
                        SC_SHIFT_DOWN: begin
                            ram_we    = 1'b1;
                            ram_waddr = AW'(pipe_idx_reg - 1'b1);
                            ram_wdata = ram_rdata;
                        end
                        SC_SEARCH: begin
                            if (!(ram_rdata < val_reg)) begin
                                // first entry not less than the value: open a slot here
                                place_next    = pipe_idx_reg;
                                rindex_next   = pipe_idx_reg;
                                op_next       = SC_SHIFT_UP;
                                rd_idx_next   = count_reg - 1'b1;
                                rem_next      = count_reg - pipe_idx_reg;
                                pipe_vld_next = 1'b0;
                            end
                        end
                        SC_REMOVE: begin
                            if (ram_rdata == val_reg) begin
                                hit_next = hit_reg + 1'b1;
                            end else begin
                                ram_we      = 1'b1;
                                ram_waddr   = wr_idx_reg[AW-1:0];
                                ram_wdata   = ram_rdata;
                                wr_idx_next = wr_idx_reg + 1'b1;
                            end
                        end
                        SC_GET: begin
                            status_next = 1'b0;
                            rvalue_next = ram_rdata;
                        end
                        SC_FIND: begin
                            if (ram_rdata == val_reg) begin
                                status_next   = 1'b0;
                                rindex_next   = pipe_idx_reg;
                                pipe_vld_next = 1'b0;
                                state_next    = ST_FIN;
                            end
                        end
                        default: begin
                        end
                    endcase
                end else if (rem_reg == '0) begin
                    case (op_reg)
                        SC_SHIFT_UP: begin
                            state_next = ST_PLACE;
                        end
                        SC_SEARCH: begin
                            place_next  = count_reg;
                            rindex_next = count_reg;
                            state_next  = ST_PLACE;
                        end
                        SC_REMOVE: begin
                            count_next  = wr_idx_reg;
                            rindex_next = hit_reg;
                            state_next  = ST_FIN;
                        end
                        default: begin
                            state_next = ST_FIN;
                        end
                    endcase
                end
            end
            ST_PLACE: begin
                ram_we     = 1'b1;
                ram_waddr  = place_reg[AW-1:0];
                ram_wdata  = val_reg;
                count_next = count_reg + 1'b1;
                state_next = ST_FIN;
            end
            ST_FIN: begin
                ctl_o.res_valid = 1'b1;
                if (ctl_i.res_ready) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

// ----- rtl/core/indexed_sequence_table_core.sv -----
// Top level of the indexed sequence table: ports, capacity register, output register.
// Flow: accept, decide, walk the entries as needed, write a slot when needed, then register
// the result; walks go through the single store read port, one entry a cycle.
// Throughput: one item at a time; the next item is taken the cycle after its result enters
// the output register, which holds it until m_tready.
// Reset: occupancy zero, capacity 256, no result pending; store contents are not cleared.
`default_nettype none

module indexed_sequence_table_core import ist_pkg::*; #(
    parameter int DEPTH       = 256,
    parameter int VALUE_WIDTH = 32
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        cfg_wr_en,
    input  wire logic [8:0]  cfg_wr_data,  // capacity
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [47:0] s_tdata,      // req_type[2:0], position[11:3], value[43:12]
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic      [55:0] m_tdata       // status[0], result_index[9:1],
                                           // result_value[41:10], occupancy[50:42]
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int WW = (CW > FIELD_W) ? CW : FIELD_W;

    logic [8:0]             cap_reg;
    logic                   out_vld_reg, out_vld_next;
    logic [55:0]            out_data_reg, out_data_next;
    logic [WW-1:0]          cap_w;
    logic [WW-1:0]          eff_w;
    ist_ctl_in_t            ctl_in;
    ist_ctl_out_t           ctl_out;
    logic                   res_status;
    logic [FIELD_W-1:0]     res_index;
    logic [DATA_W-1:0]      res_value;
    logic [FIELD_W-1:0]     res_occupancy;
    logic                   ram_we;
    logic [AW-1:0]          ram_waddr;
    logic [VALUE_WIDTH-1:0] ram_wdata;
    logic [AW-1:0]          ram_raddr;
    logic [VALUE_WIDTH-1:0] ram_rdata;

    assign cap_w = WW'(cap_reg);
    assign eff_w = (cap_w > WW'(DEPTH)) ? WW'(DEPTH) : cap_w;

    assign ctl_in.req_valid = s_tvalid;
    assign ctl_in.res_ready = !out_vld_reg || m_tready;
    assign s_tready         = ctl_out.req_ready;
    assign m_tvalid         = out_vld_reg;
    assign m_tdata          = out_data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cap_reg     <= 9'd256;
            out_vld_reg <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                cap_reg <= cfg_wr_data;
            end
            out_vld_reg <= out_vld_next;
        end
        out_data_reg <= out_data_next;
    end

    always_comb begin
        out_vld_next  = out_vld_reg;
        out_data_next = out_data_reg;
        if (ctl_out.res_valid && ctl_in.res_ready) begin
            out_vld_next  = 1'b1;
            out_data_next = {5'd0, res_occupancy, res_value, res_index, res_status};
        end else if (m_tready) begin
            out_vld_next = 1'b0;
        end
    end

    ist_seq #(
        .DEPTH       (DEPTH),
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_seq (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .ctl_i         (ctl_in),
        .ctl_o         (ctl_out),
        .req_type      (s_tdata[2:0]),
        .req_position  (s_tdata[11:3]),
        .req_value     (s_tdata[43:12]),
        .eff_capacity  (eff_w[CW-1:0]),
        .res_status    (res_status),
        .res_index     (res_index),
        .res_value     (res_value),
        .res_occupancy (res_occupancy),
        .ram_we        (ram_we),
        .ram_waddr     (ram_waddr),
        .ram_wdata     (ram_wdata),
        .ram_raddr     (ram_raddr),
        .ram_rdata     (ram_rdata)
    );

    ist_ram #(
        .WIDTH (VALUE_WIDTH),
        .DEPTH (DEPTH)
    ) u_store (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

endmodule

`default_nettype wire
